// ===== hdl/gbp_pkg.sv =====
// Package for the glyph bitmap packer: mode codes, glyph sides, field widths
// and the small arithmetic helper used by the top-level packer.
// Depends on nothing.
package gbp_pkg;

    localparam int SOURCE_SIDE_DEF = 24;

    localparam int PIX_W = 8;
    localparam int EXT_W = 6;
    localparam int ROW_W = 32;
    localparam int IDX_W = 4;
    localparam int MODE_W = 2;
    localparam int NIB_W = 4;

    localparam logic [MODE_W-1:0] MODE_BIT16 = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BIT12 = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUAD = 2'd2;

    localparam int SIDE_BIT16 = 16;
    localparam int SIDE_BIT12 = 12;

    localparam logic [NIB_W-1:0] NIBBLE_MAX = 4'hf;

    // Width divided by three as a multiply by a reciprocal; exact below 128.
    function automatic logic [EXT_W-1:0] div3(input logic [EXT_W-1:0] w);
        logic [EXT_W+6:0] p;
        p = (EXT_W+7)'(w) * (EXT_W+7)'(43);
        return p[EXT_W+6:7];
    endfunction

endpackage

// ===== hdl/glyph_bitmap_packer.sv =====
// Glyph bitmap packer, top level. Depends on gbp_pkg and gbp_ram.
// Packs a glyph's pixel stream into font row words.
//
// The block takes one pixel beat per clock cycle while the output is not stalled. A stalled
// output holds back the input only once the next row word is waiting behind it. A row word
// enters the output register from stage 1. Each pixel makes one read of the line store RAM
// when it is accepted and, in the four-bit mode except on every third row, one write of
// the same column in the next cycle. Each RAM word holds the two earlier source rows of one
// column, and the 3x3 sums are built column by column in registers. The line store is not
// cleared after reset, and the first rows of a four-bit glyph overwrite it before they are
// read. A write to glyph_mode restarts the glyph; write it only while the block is idle.
module glyph_bitmap_packer
    import gbp_pkg::*;
#(
    parameter int SOURCE_SIDE = SOURCE_SIDE_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [PIX_W-1:0]  i_intensity,
    input  logic [EXT_W-1:0]  i_text_extent,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [ROW_W-1:0]  o_row_bits,
    output logic [IDX_W-1:0]  o_row_index,
    output logic [EXT_W-1:0]  o_glyph_width,
    output logic              o_last,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_glyph_mode
);

    localparam int CW = $clog2(SOURCE_SIDE);
    localparam int TW = $clog2(SOURCE_SIDE / 3);
    localparam int SW = PIX_W + 2;
    localparam int HW = SW + 2;
    localparam logic [CW-1:0] SIDE_Q = CW'(SOURCE_SIDE);
    localparam logic [CW-1:0] SIDE_16 = CW'(SIDE_BIT16);
    localparam logic [CW-1:0] SIDE_12 = CW'(SIDE_BIT12);

    logic [MODE_W-1:0] r_mode;
    logic [CW-1:0]     r_col, r_row;
    logic [1:0]        r_col_ph, r_row_ph;
    logic [TW-1:0]     r_col_tri, r_row_tri;

    logic              r_s1_valid;
    logic [PIX_W-1:0]  r_s1_pix;
    logic [EXT_W-1:0]  r_s1_ext;
    logic [CW-1:0]     r_s1_col;
    logic [1:0]        r_s1_col_ph;
    logic [TW-1:0]     r_s1_col_tri;
    logic              r_s1_slot2;
    logic              r_s1_first, r_s1_emit, r_s1_fin;
    logic [IDX_W-1:0]  r_s1_idx;

    logic [ROW_W-1:0]  r_acc, n_acc;
    logic [EXT_W-1:0]  r_widest, n_widest;
    logic [HW-1:0]     r_hsum;

    logic              r_out_valid;
    logic [ROW_W-1:0]  r_row_bits;
    logic [IDX_W-1:0]  r_row_index;
    logic [EXT_W-1:0]  r_glyph_width;
    logic              r_last;

    logic              quad, out_free, s1_go, in_acc, cfg_wr;
    logic [CW-1:0]     side, col_c, row_c;
    logic [1:0]        col_ph_c, row_ph_c;
    logic [TW-1:0]     col_tri_c, row_tri_c;
    logic              end_col, end_row;

    logic [2*PIX_W-1:0] rd_data;
    logic               wr_en;
    logic [SW-1:0]      col_sum;
    logic [HW-1:0]      tot_sum;
    logic [NIB_W-1:0]   nib;
    logic [EXT_W-1:0]   base_w;

    assign quad = (r_mode == MODE_QUAD);
    always_comb begin
        unique case (r_mode)
            MODE_QUAD:  side = SIDE_Q;
            MODE_BIT12: side = SIDE_12;
            default:    side = SIDE_16;
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_go = r_s1_valid && (out_free || !r_s1_emit);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_acc = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_wr = i_cfg_valid;

    always_comb begin
        if (r_col >= side) begin
            col_c = '0;
            col_ph_c = '0;
            col_tri_c = '0;
        end else begin
            col_c = r_col;
            col_ph_c = r_col_ph;
            col_tri_c = r_col_tri;
        end
        if (r_row >= side) begin
            row_c = '0;
            row_ph_c = '0;
            row_tri_c = '0;
        end else begin
            row_c = r_row;
            row_ph_c = r_row_ph;
            row_tri_c = r_row_tri;
        end
    end

    assign end_col = (col_c == side - CW'(1));
    assign end_row = (row_c == side - CW'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_BIT16;
            r_col <= '0;
            r_row <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
            r_col_tri <= '0;
            r_row_tri <= '0;
        end else if (cfg_wr) begin
            r_mode <= i_glyph_mode;
            r_col <= '0;
            r_row <= '0;
            r_col_ph <= '0;
            r_row_ph <= '0;
            r_col_tri <= '0;
            r_row_tri <= '0;
        end else if (in_acc) begin
            if (end_col) begin
                r_col <= '0;
                r_col_ph <= '0;
                r_col_tri <= '0;
                if (end_row) begin
                    r_row <= '0;
                    r_row_ph <= '0;
                    r_row_tri <= '0;
                end else begin
                    r_row <= row_c + CW'(1);
                    if (row_ph_c == 2'd2) begin
                        r_row_ph <= '0;
                        r_row_tri <= row_tri_c + TW'(1);
                    end else begin
                        r_row_ph <= row_ph_c + 2'd1;
                        r_row_tri <= row_tri_c;
                    end
                end
            end else begin
                r_col <= col_c + CW'(1);
                r_row <= row_c;
                r_row_ph <= row_ph_c;
                r_row_tri <= row_tri_c;
                if (col_ph_c == 2'd2) begin
                    r_col_ph <= '0;
                    r_col_tri <= col_tri_c + TW'(1);
                end else begin
                    r_col_ph <= col_ph_c + 2'd1;
                    r_col_tri <= col_tri_c;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_pix <= i_intensity;
            r_s1_ext <= i_text_extent;
            r_s1_col <= col_c;
            r_s1_col_ph <= col_ph_c;
            r_s1_col_tri <= col_tri_c;
            r_s1_slot2 <= (row_ph_c == 2'd2);
            r_s1_first <= (col_c == '0) && (row_c == '0);
            r_s1_emit <= end_col && (!quad || row_ph_c == 2'd2);
            r_s1_fin <= end_row;
            r_s1_idx <= quad ? IDX_W'(row_tri_c) : IDX_W'(row_c);
        end
    end

    assign wr_en = s1_go && quad && !r_s1_slot2;

    gbp_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (SOURCE_SIDE)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_col),
        .i_wr_data ({rd_data[PIX_W-1:0], r_s1_pix}),
        .i_rd_en   (in_acc),
        .i_rd_addr (col_c),
        .o_rd_data (rd_data)
    );

    assign col_sum = SW'(rd_data[2*PIX_W-1:PIX_W]) + {1'b0, rd_data[PIX_W-1:0], 1'b0}
                   + SW'(r_s1_pix);
    assign tot_sum = r_hsum + HW'(col_sum);

    always_comb begin
        if (tot_sum[HW-1:7] > (HW-7)'(NIBBLE_MAX)) begin
            nib = NIBBLE_MAX;
        end else begin
            nib = tot_sum[7+NIB_W-1:7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && quad && r_s1_slot2) begin
            unique case (r_s1_col_ph)
                2'd0:    r_hsum <= HW'(col_sum);
                2'd1:    r_hsum <= r_hsum + {1'b0, col_sum, 1'b0};
                default: r_hsum <= r_hsum;
            endcase
        end
    end

    always_comb begin
        base_w = r_s1_first ? r_s1_ext : r_widest;
        n_widest = base_w;
        n_acc = r_acc;
        if (!quad) begin
            if (r_s1_pix != '0) begin
                n_acc = r_acc | (ROW_W'(1) << r_s1_col);
                if (EXT_W'(r_s1_col) > base_w) begin
                    n_widest = EXT_W'(r_s1_col);
                end
            end
        end else if (r_s1_slot2 && r_s1_col_ph == 2'd2 && nib != '0) begin
            n_acc = r_acc | (ROW_W'(nib) << {r_s1_col_tri, 2'b00});
            if (EXT_W'(r_s1_col_tri) > base_w) begin
                n_widest = EXT_W'(r_s1_col_tri);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_widest <= '0;
        end else if (cfg_wr) begin
            r_acc <= '0;
        end else if (s1_go) begin
            r_acc <= r_s1_emit ? '0 : n_acc;
            r_widest <= n_widest;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go && r_s1_emit) begin
            r_row_bits <= n_acc;
            r_row_index <= r_s1_idx;
            r_last <= r_s1_fin;
            if (r_s1_fin) begin
                r_glyph_width <= quad ? div3(n_widest) : n_widest;
            end else begin
                r_glyph_width <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_row_bits = r_row_bits;
    assign o_row_index = r_row_index;
    assign o_glyph_width = r_glyph_width;
    assign o_last = r_last;

endmodule

// ===== hdl/gbp_ram.sv =====
// Generic single-clock RAM with one write port and one registered read port.
// Depends on nothing.
module gbp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
